@@ hw/rtl/kcl_pkg.sv @@
// Shared types, key and event codes for the keypad code lock controller.
// No dependencies; imported by keypad_code_lock_controller and its testbench.
package kcl_pkg;

    localparam int MAX_DIGITS = 8;
    localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int COUNT_W    = $clog2(MAX_DIGITS + 1);

    localparam int KEY_W      = 4;
    localparam int EVENT_W    = 4;
    localparam int TIMER_W    = 16;
    localparam int ATTEMPT_W  = 3;
    localparam int ENTERED_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int INIT_LEN_INT = (MAX_DIGITS < 4) ? MAX_DIGITS : 4;
    localparam logic [COUNT_W-1:0] INIT_LENGTH = COUNT_W'(INIT_LEN_INT);

    localparam logic [TIMER_W-1:0]   AUTO_CLOSE_RESET   = 16'd5000;
    localparam logic [TIMER_W-1:0]   MESSAGE_RESET      = 16'd2000;
    localparam logic [TIMER_W-1:0]   LOCKOUT_RESET      = 16'd5000;
    localparam logic [ATTEMPT_W-1:0] MAX_ATTEMPTS_RESET = 3'd3;
    localparam logic [ATTEMPT_W-1:0] WRONG_MAX          = 3'd7;

    typedef logic [KEY_W-1:0] symbol_t;

    localparam symbol_t KEY_A    = 4'd10;
    localparam symbol_t KEY_D    = 4'd13;
    localparam symbol_t KEY_STAR = 4'd14;
    localparam symbol_t KEY_HASH = 4'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AUTO_CLOSE   = 2'd0,
        CFG_MESSAGE      = 2'd1,
        CFG_LOCKOUT      = 2'd2,
        CFG_MAX_ATTEMPTS = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        MODE_NORMAL = 4'b0001,
        MODE_VERIFY = 4'b0010,
        MODE_CHANGE = 4'b0100,
        MODE_LOCK   = 4'b1000
    } mode_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE        = 4'd0,
        EV_KEY_STORED  = 4'd1,
        EV_CLEARED     = 4'd2,
        EV_MANUAL      = 4'd3,
        EV_GRANTED     = 4'd4,
        EV_WRONG       = 4'd5,
        EV_OLD_OK      = 4'd6,
        EV_OLD_WRONG   = 4'd7,
        EV_CHANGED     = 4'd8,
        EV_CHANGE_BEG  = 4'd9,
        EV_IGNORED     = 4'd10,
        EV_AUTO_CLOSED = 4'd11,
        EV_LOCK_OVER   = 4'd12,
        EV_LIGHT_OFF   = 4'd13,
        EV_REJECTED    = 4'd14
    } event_t;

    // Factory code 1,2,3,4, remaining positions zero
    function automatic symbol_t init_symbol(input int i);
        symbol_t s;
        s = '0;
        if (i < 4)
            s = KEY_W'(i + 1);
        return s;
    endfunction

    function automatic logic [TIMER_W-1:0] count_up(input logic [TIMER_W-1:0] t);
        logic [TIMER_W-1:0] r;
        r = (t == '1) ? t : t + 1'b1;
        return r;
    endfunction

endpackage

@@ hw/rtl/keypad_code_lock_controller.sv @@
// Keypad code lock controller: entry buffer, code compare, change, lockout, timers.
// Depends on kcl_pkg.

// Each transaction is a key press (op = 0) or a one-millisecond tick (op = 1) and
// yields exactly one result: an event code plus the door, light, lockout, attempts
// and entry-count status after the update. One transaction is taken per clock while
// in_stall is low. The input register takes the transaction at the accepting edge,
// and a single pass of next-state logic with a parallel code compare loads the
// result register as soon as that register is empty or being read.
// in_stall rises only while the result register is full and out_stall is high.
// Configuration writes take effect at once and should only be made while idle.
module keypad_code_lock_controller
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_we,
    input  logic [kcl_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [kcl_pkg::CFG_DATA_W-1:0]        cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  op,
    input  logic [kcl_pkg::KEY_W-1:0]             key_code,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [kcl_pkg::EVENT_W-1:0]           event_res,
    output logic                                  door_open,
    output logic                                  green_light,
    output logic                                  locked_out,
    output logic [kcl_pkg::ATTEMPT_W-1:0]         attempts_left,
    output logic [kcl_pkg::ENTERED_W-1:0]         entered_count
);
    import kcl_pkg::*;

    // configuration
    logic [TIMER_W-1:0]   auto_close_reg;
    logic [TIMER_W-1:0]   message_reg;
    logic [TIMER_W-1:0]   lockout_reg;
    logic [ATTEMPT_W-1:0] max_attempts_reg;

    // input stage
    logic                 s1_valid_reg;
    logic                 s1_op_reg;
    symbol_t              s1_key_reg;

    // lock state
    symbol_t              stored_code_reg [MAX_DIGITS];
    symbol_t              stored_code_next[MAX_DIGITS];
    logic [COUNT_W-1:0]   stored_len_reg, stored_len_next;
    symbol_t              entry_buf_reg   [MAX_DIGITS];
    logic                 buf_we;
    logic [COUNT_W-1:0]   entry_len_reg, entry_len_next;
    logic                 overflow_reg, overflow_next;
    mode_t                mode_reg, mode_next;
    logic [ATTEMPT_W-1:0] wrong_reg, wrong_next;
    logic                 door_reg, door_next;
    logic [TIMER_W-1:0]   door_timer_reg, door_timer_next;
    logic                 light_reg, light_next;
    logic [TIMER_W-1:0]   light_timer_reg, light_timer_next;
    logic [TIMER_W-1:0]   lock_timer_reg, lock_timer_next;
    event_t               event_next;

    // result register
    logic                 out_valid_reg;
    event_t               out_event_reg;
    logic                 out_door_reg;
    logic                 out_green_reg;
    logic                 out_locked_reg;
    logic [ATTEMPT_W-1:0] out_attempts_reg;
    logic [COUNT_W-1:0]   out_count_reg;

    logic                 s1_fire;
    logic                 in_fire;
    logic                 entry_match;
    logic [ATTEMPT_W-1:0] attempts_next;

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_fire  = in_valid && !in_stall;

    // Parallel compare over the valid part of the entry
    always_comb
    begin
        logic all_eq;
        all_eq = 1'b1;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if ((COUNT_W'(i) < entry_len_reg) && (entry_buf_reg[i] != stored_code_reg[i]))
                all_eq = 1'b0;
        end
        entry_match = all_eq && !overflow_reg && (entry_len_reg == stored_len_reg);
    end

    always_comb
    begin
        logic [TIMER_W-1:0] t_door;
        logic [TIMER_W-1:0] t_lock;
        logic [TIMER_W-1:0] t_light;
        logic               closed;
        logic               unlocked;
        logic               dark;
        logic [ATTEMPT_W-1:0] wrong_inc;

        stored_code_next = stored_code_reg;
        stored_len_next  = stored_len_reg;
        buf_we           = 1'b0;
        entry_len_next   = entry_len_reg;
        overflow_next    = overflow_reg;
        mode_next        = mode_reg;
        wrong_next       = wrong_reg;
        door_next        = door_reg;
        door_timer_next  = door_timer_reg;
        light_next       = light_reg;
        light_timer_next = light_timer_reg;
        lock_timer_next  = lock_timer_reg;
        event_next       = EV_NONE;
        closed           = 1'b0;
        unlocked         = 1'b0;
        dark             = 1'b0;
        t_door           = count_up(door_timer_reg);
        t_lock           = count_up(lock_timer_reg);
        t_light          = count_up(light_timer_reg);
        wrong_inc        = (wrong_reg == WRONG_MAX) ? wrong_reg : wrong_reg + 1'b1;

        if (s1_op_reg)
        begin
            if (door_reg)
            begin
                door_timer_next = t_door;
                if (t_door >= auto_close_reg)
                begin
                    door_next       = 1'b0;
                    door_timer_next = '0;
                    closed          = 1'b1;
                end
            end
            if (mode_reg == MODE_LOCK)
            begin
                lock_timer_next = t_lock;
                if (t_lock >= lockout_reg)
                begin
                    mode_next       = MODE_NORMAL;
                    lock_timer_next = '0;
                    wrong_next      = '0;
                    unlocked        = 1'b1;
                end
            end
            if (light_reg)
            begin
                light_timer_next = t_light;
                if (t_light >= message_reg)
                begin
                    light_next       = 1'b0;
                    light_timer_next = '0;
                    dark             = 1'b1;
                end
            end
            if (closed)
                event_next = EV_AUTO_CLOSED;
            else if (unlocked)
                event_next = EV_LOCK_OVER;
            else if (dark)
                event_next = EV_LIGHT_OFF;
        end
        else if (mode_reg == MODE_LOCK)
        begin
            event_next = EV_IGNORED;
        end
        else
        begin
            case (s1_key_reg)
                KEY_D:
                begin
                    door_next       = 1'b0;
                    door_timer_next = '0;
                    event_next      = EV_MANUAL;
                end
                KEY_STAR:
                begin
                    entry_len_next = '0;
                    overflow_next  = 1'b0;
                    event_next     = EV_CLEARED;
                end
                KEY_A:
                begin
                    mode_next      = MODE_VERIFY;
                    entry_len_next = '0;
                    overflow_next  = 1'b0;
                    event_next     = EV_CHANGE_BEG;
                end
                KEY_HASH:
                begin
                    entry_len_next = '0;
                    overflow_next  = 1'b0;
                    case (mode_reg)
                        MODE_VERIFY:
                        begin
                            mode_next  = entry_match ? MODE_CHANGE : MODE_NORMAL;
                            event_next = entry_match ? EV_OLD_OK : EV_OLD_WRONG;
                        end
                        MODE_CHANGE:
                        begin
                            mode_next = MODE_NORMAL;
                            if (overflow_reg)
                                event_next = EV_REJECTED;
                            else
                            begin
                                stored_code_next = entry_buf_reg;
                                stored_len_next  = entry_len_reg;
                                event_next       = EV_CHANGED;
                            end
                        end
                        default:
                        begin
                            if (entry_match)
                            begin
                                door_next        = 1'b1;
                                door_timer_next  = '0;
                                light_next       = 1'b1;
                                light_timer_next = '0;
                                wrong_next       = '0;
                                event_next       = EV_GRANTED;
                            end
                            else
                            begin
                                wrong_next = wrong_inc;
                                if (wrong_inc >= max_attempts_reg)
                                begin
                                    mode_next       = MODE_LOCK;
                                    lock_timer_next = '0;
                                end
                                event_next = EV_WRONG;
                            end
                        end
                    endcase
                end
                default:
                begin
                    // digits, B and C
                    if (entry_len_reg < COUNT_W'(MAX_DIGITS))
                    begin
                        buf_we         = 1'b1;
                        entry_len_next = entry_len_reg + 1'b1;
                    end
                    else
                        overflow_next = 1'b1;
                    event_next = EV_KEY_STORED;
                end
            endcase
        end

        attempts_next = (max_attempts_reg > wrong_next) ? max_attempts_reg - wrong_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_close_reg   <= AUTO_CLOSE_RESET;
            message_reg      <= MESSAGE_RESET;
            lockout_reg      <= LOCKOUT_RESET;
            max_attempts_reg <= MAX_ATTEMPTS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_AUTO_CLOSE:   auto_close_reg   <= cfg_data;
                CFG_MESSAGE:      message_reg      <= cfg_data;
                CFG_LOCKOUT:      lockout_reg      <= cfg_data;
                CFG_MAX_ATTEMPTS: max_attempts_reg <= cfg_data[ATTEMPT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg  <= op;
            s1_key_reg <= key_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_DIGITS; i++)
                stored_code_reg[i] <= init_symbol(i);
            stored_len_reg  <= INIT_LENGTH;
            entry_len_reg   <= '0;
            overflow_reg    <= 1'b0;
            mode_reg        <= MODE_NORMAL;
            wrong_reg       <= '0;
            door_reg        <= 1'b0;
            door_timer_reg  <= '0;
            light_reg       <= 1'b0;
            light_timer_reg <= '0;
            lock_timer_reg  <= '0;
        end
        else if (s1_fire)
        begin
            stored_code_reg <= stored_code_next;
            stored_len_reg  <= stored_len_next;
            entry_len_reg   <= entry_len_next;
            overflow_reg    <= overflow_next;
            mode_reg        <= mode_next;
            wrong_reg       <= wrong_next;
            door_reg        <= door_next;
            door_timer_reg  <= door_timer_next;
            light_reg       <= light_next;
            light_timer_reg <= light_timer_next;
            lock_timer_reg  <= lock_timer_next;
        end
    end

    // Entry buffer has no reset: only positions below the entry length are ever compared
    always_ff @(posedge clk)
    begin
        if (s1_fire && buf_we)
            entry_buf_reg[entry_len_reg[IDX_W-1:0]] <= s1_key_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_event_reg    <= event_next;
            out_door_reg     <= door_next;
            out_green_reg    <= light_next;
            out_locked_reg   <= (mode_next == MODE_LOCK);
            out_attempts_reg <= attempts_next;
            out_count_reg    <= entry_len_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_res     = out_event_reg;
    assign door_open     = out_door_reg;
    assign green_light   = out_green_reg;
    assign locked_out    = out_locked_reg;
    assign attempts_left = out_attempts_reg;
    assign entered_count = ENTERED_W'(out_count_reg);

endmodule

@@ tb/keypad_code_lock_controller_tb.sv @@
// Self-checking testbench for keypad_code_lock_controller: directed and random key/tick traffic.
// Holds its own model of the lock in a scoreboard class and checks each result as it arrives.
// Depends on kcl_pkg and keypad_code_lock_controller.
module keypad_code_lock_controller_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import kcl_pkg::*;

    localparam symbol_t KEY_B       = 4'd11;
    localparam symbol_t KEY_C       = 4'd12;
    localparam int      IDLE_LIMIT  = 1000;
    localparam int      HOLD_CYCLES = 60;
    localparam int      REPORT_MAX  = 10;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_style_t;

    typedef struct packed {
        event_t                 ev;
        logic                   door;
        logic                   light;
        logic                   lock;
        logic [ATTEMPT_W-1:0]   left;
        logic [ENTERED_W-1:0]   count;
    } lock_status_t;

    // Lock behaviour tracked per transaction; expected status words queued in order
    class lock_scoreboard;
        logic [TIMER_W-1:0]   close_limit;
        logic [TIMER_W-1:0]   light_limit;
        logic [TIMER_W-1:0]   lockout_limit;
        logic [ATTEMPT_W-1:0] attempt_limit;

        symbol_t      code [MAX_DIGITS];
        int unsigned  code_len;
        symbol_t      entry [MAX_DIGITS];
        int unsigned  entry_len;
        bit           overflow;
        mode_t        mode;
        int unsigned  wrong;
        bit           door;
        logic [TIMER_W-1:0] door_t;
        bit           light;
        logic [TIMER_W-1:0] light_t;
        logic [TIMER_W-1:0] lock_t;

        lock_status_t status_q [$];
        int           failures;
        int           checked;
        bit [14:0]    seen_events;

        function new();
            close_limit   = AUTO_CLOSE_RESET;
            light_limit   = MESSAGE_RESET;
            lockout_limit = LOCKOUT_RESET;
            attempt_limit = MAX_ATTEMPTS_RESET;
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                code[i]  = (i < 4) ? symbol_t'(i + 1) : '0;
                entry[i] = '0;
            end
            code_len    = (MAX_DIGITS < 4) ? MAX_DIGITS : 4;
            entry_len   = 0;
            overflow    = 0;
            mode        = MODE_NORMAL;
            wrong       = 0;
            door        = 0;
            door_t      = '0;
            light       = 0;
            light_t     = '0;
            lock_t      = '0;
            failures    = 0;
            checked     = 0;
            seen_events = '0;
        endfunction

        function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_AUTO_CLOSE:   close_limit   = value;
                CFG_MESSAGE:      light_limit   = value;
                CFG_LOCKOUT:      lockout_limit = value;
                CFG_MAX_ATTEMPTS: attempt_limit = value[ATTEMPT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [TIMER_W-1:0] bump(logic [TIMER_W-1:0] t);
            return (t == '1) ? t : t + 1'b1;
        endfunction

        function bit code_matches();
            if (overflow || entry_len != code_len)
                return 0;
            for (int i = 0; i < entry_len; i++)
                if (entry[i] != code[i])
                    return 0;
            return 1;
        endfunction

        function void clear_entry();
            entry_len = 0;
            overflow  = 0;
        endfunction

        function event_t tick_step();
            bit closed;
            bit unlocked;
            bit dark;
            closed   = 0;
            unlocked = 0;
            dark     = 0;
            if (door)
            begin
                door_t = bump(door_t);
                if (door_t >= close_limit)
                begin
                    door   = 0;
                    door_t = '0;
                    closed = 1;
                end
            end
            if (mode == MODE_LOCK)
            begin
                lock_t = bump(lock_t);
                if (lock_t >= lockout_limit)
                begin
                    mode     = MODE_NORMAL;
                    lock_t   = '0;
                    wrong    = 0;
                    unlocked = 1;
                end
            end
            if (light)
            begin
                light_t = bump(light_t);
                if (light_t >= light_limit)
                begin
                    light   = 0;
                    light_t = '0;
                    dark    = 1;
                end
            end
            // several expiries on one tick: door beats lockout beats light
            if (closed)
                return EV_AUTO_CLOSED;
            if (unlocked)
                return EV_LOCK_OVER;
            if (dark)
                return EV_LIGHT_OFF;
            return EV_NONE;
        endfunction

        function event_t hash_step();
            event_t ev;
            if (mode == MODE_VERIFY)
            begin
                if (code_matches())
                begin
                    mode = MODE_CHANGE;
                    ev   = EV_OLD_OK;
                end
                else
                begin
                    mode = MODE_NORMAL;
                    ev   = EV_OLD_WRONG;
                end
            end
            else if (mode == MODE_CHANGE)
            begin
                mode = MODE_NORMAL;
                if (overflow)
                    ev = EV_REJECTED;
                else
                begin
                    code     = entry;
                    code_len = entry_len;
                    ev       = EV_CHANGED;
                end
            end
            else if (code_matches())
            begin
                door    = 1;
                door_t  = '0;
                light   = 1;
                light_t = '0;
                wrong   = 0;
                ev      = EV_GRANTED;
            end
            else
            begin
                if (wrong < WRONG_MAX)
                    wrong++;
                if (wrong >= attempt_limit)
                begin
                    mode   = MODE_LOCK;
                    lock_t = '0;
                end
                ev = EV_WRONG;
            end
            clear_entry();
            return ev;
        endfunction

        function event_t key_step(symbol_t k);
            if (mode == MODE_LOCK)
                return EV_IGNORED;
            if (k == KEY_D)
            begin
                door   = 0;
                door_t = '0;
                return EV_MANUAL;
            end
            if (k == KEY_STAR)
            begin
                clear_entry();
                return EV_CLEARED;
            end
            if (k == KEY_HASH)
                return hash_step();
            if (k == KEY_A)
            begin
                mode = MODE_VERIFY;
                clear_entry();
                return EV_CHANGE_BEG;
            end
            if (entry_len < MAX_DIGITS)
            begin
                entry[entry_len] = k;
                entry_len++;
            end
            else
                overflow = 1;
            return EV_KEY_STORED;
        endfunction

        function void note_input(bit is_tick, symbol_t k);
            lock_status_t s;
            s.ev    = is_tick ? tick_step() : key_step(k);
            s.door  = door;
            s.light = light;
            s.lock  = (mode == MODE_LOCK);
            s.left  = (attempt_limit > wrong) ? ATTEMPT_W'(attempt_limit - wrong) : '0;
            s.count = ENTERED_W'(entry_len);
            seen_events[s.ev] = 1'b1;
            status_q.push_back(s);
        endfunction

        function void check_result(lock_status_t got);
            lock_status_t exp;
            if (status_q.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("%0t: result with nothing expected: ev=%0d", $realtime, got.ev);
                return;
            end
            exp = status_q.pop_front();
            checked++;
            if (got.ev !== exp.ev || got.door !== exp.door || got.light !== exp.light ||
                got.lock !== exp.lock || got.left !== exp.left || got.count !== exp.count)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("%0t: mismatch ev/door/light/lock/left/count exp %0d/%0b/%0b/%0b/%0d/%0d got %0d/%0b/%0b/%0b/%0d/%0d",
                             $realtime, exp.ev, exp.door, exp.light, exp.lock, exp.left,
                             exp.count, got.ev, got.door, got.light, got.lock, got.left,
                             got.count);
            end
        endfunction

        function int pending();
            return status_q.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  op = 1'b0;
    logic [KEY_W-1:0]      key_code = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [EVENT_W-1:0]    event_res;
    logic                  door_open;
    logic                  green_light;
    logic                  locked_out;
    logic [ATTEMPT_W-1:0]  attempts_left;
    logic [ENTERED_W-1:0]  entered_count;

    lock_scoreboard sb = new();

    int           items_sent = 0;
    int           burst_left = 0;
    bit           gaps_on = 1'b1;
    stall_style_t stall_style = STALL_NONE;
    bit           hold_req = 1'b0;
    int           idle_cycles = 0;
    int           input_held = 0;
    int           settings_used = 0;

    keypad_code_lock_controller u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .key_code      (key_code),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_res     (event_res),
        .door_open     (door_open),
        .green_light   (green_light),
        .locked_out    (locked_out),
        .attempts_left (attempts_left),
        .entered_count (entered_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: check every accepted transaction against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{event_t'(event_res), door_open, green_light, locked_out,
                              attempts_left, entered_count});
    end

    // Receiver stall pattern, with a long hold-off on request to back the block up
    always
    begin
        int cyc;
        @(posedge clk);
        cyc++;
        if (hold_req)
        begin
            hold_req = 1'b0;
            out_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (stall_style)
            STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
            STALL_PERIODIC: out_stall <= ((cyc % 7) < 3);
            default:        out_stall <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_stall)
                input_held++;
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: watchdog, no transaction for %0d cycles", $realtime, IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_item(bit o, symbol_t k);
        in_valid <= 1'b1;
        op       <= o;
        key_code <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(o, k);
        items_sent++;
    endtask

    // Sender bursts: random length, random gap in front of each when gaps are on
    task automatic offer(bit o, symbol_t k);
        int gap;
        if (burst_left == 0)
        begin
            if (gaps_on)
            begin
                gap = $urandom_range(1, 8);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        send_item(o, k);
    endtask

    function automatic symbol_t rand_symbol();
        int r;
        r = $urandom_range(0, 11);
        if (r == 10)
            return KEY_B;
        if (r == 11)
            return KEY_C;
        return symbol_t'(r);
    endfunction

    task automatic key_in_code(symbol_t pin [MAX_DIGITS], int unsigned plen);
        for (int i = 0; i < plen; i++)
            offer(1'b0, pin[i]);
    endtask

    task automatic send_sequence();
        symbol_t     pin [MAX_DIGITS];
        int unsigned plen;
        int          kind;
        int          n;
        pin  = sb.code;
        plen = sb.code_len;
        if (sb.mode == MODE_LOCK)
        begin
            // locked: mostly ticks to run the lockout down, some keys that must be ignored
            if ($urandom_range(0, 4) != 0)
                repeat ($urandom_range(1, 8)) offer(1'b1, symbol_t'($urandom_range(0, 15)));
            else
                offer(1'b0, symbol_t'($urandom_range(0, 15)));
            return;
        end
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            key_in_code(pin, plen);
            offer(1'b0, KEY_HASH);
        end
        else if (kind < 45)
        begin
            repeat ($urandom_range(0, 6)) offer(1'b0, rand_symbol());
            offer(1'b0, KEY_HASH);
        end
        else if (kind < 60)
        begin
            offer(1'b0, KEY_A);
            if ($urandom_range(0, 4) != 0)
                key_in_code(pin, plen);
            else
                repeat ($urandom_range(0, 5)) offer(1'b0, rand_symbol());
            offer(1'b0, KEY_HASH);
            if ($urandom_range(0, 4) == 0)
            begin
                // restart mid-change
                offer(1'b0, KEY_A);
                key_in_code(pin, plen);
                offer(1'b0, KEY_HASH);
            end
            // nine symbols overflow the buffer and get the change rejected
            n = $urandom_range(0, 9);
            repeat (n) offer(1'b0, rand_symbol());
            offer(1'b0, KEY_HASH);
        end
        else if (kind < 80)
            repeat ($urandom_range(1, 12)) offer(1'b1, symbol_t'($urandom_range(0, 15)));
        else if (kind < 90)
        begin
            repeat ($urandom_range(8, 11)) offer(1'b0, rand_symbol());
            case ($urandom_range(0, 2))
                0:       offer(1'b0, KEY_HASH);
                1:       offer(1'b0, KEY_STAR);
                default: offer(1'b0, KEY_A);
            endcase
        end
        else
            repeat ($urandom_range(1, 4))
                offer(1'($urandom_range(0, 1)), symbol_t'($urandom_range(0, 15)));
    endtask

    task automatic run_random(int count, bit gaps, stall_style_t style);
        int start;
        start       = items_sent;
        gaps_on     = gaps;
        stall_style = style;
        while (items_sent - start < count)
            send_sequence();
    endtask

    // Wait for every outstanding result, then let the pipeline settle
    task automatic drain(int settle);
        in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic apply_settings(logic [TIMER_W-1:0] close_t, logic [TIMER_W-1:0] light_t,
                                  logic [TIMER_W-1:0] lock_t, logic [ATTEMPT_W-1:0] tries);
        logic [CFG_DATA_W-1:0] vals [4];
        drain(4);
        vals = '{close_t, light_t, lock_t, CFG_DATA_W'(tries)};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            cfg_data  <= vals[i];
            sb.set_register(cfg_index_t'(i), vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        logic [4:0] script [$];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values first
        run_random(20, 1'b1, STALL_LIGHT);

        // directed walk: lockout, change to an empty code, timers, overflow
        apply_settings(16'd3, 16'd2, 16'd2, 3'd2);
        script = '{{1'b1, KEY_HASH}, {1'b0, KEY_HASH}, {1'b0, KEY_D}, {1'b0, KEY_HASH},
                   {1'b0, KEY_D}, {1'b1, 4'd0}, {1'b1, 4'd9}, {1'b0, KEY_A},
                   {1'b0, 4'd1}, {1'b0, 4'd2}, {1'b0, 4'd3}, {1'b0, 4'd4},
                   {1'b0, KEY_HASH}, {1'b0, KEY_HASH}, {1'b0, KEY_HASH}, {1'b1, 4'd5},
                   {1'b1, 4'd6}, {1'b1, 4'd7}, {1'b0, KEY_STAR}, {1'b0, KEY_B},
                   {1'b0, KEY_C}, {1'b0, 4'd0}, {1'b0, 4'd5}, {1'b0, 4'd6},
                   {1'b0, 4'd8}, {1'b0, 4'd9}, {1'b0, 4'd0}, {1'b0, 4'd1},
                   {1'b0, KEY_HASH}};
        gaps_on     = 1'b1;
        stall_style = STALL_LIGHT;
        foreach (script[i])
            offer(script[i][4], script[i][3:0]);

        // back-to-back traffic while the receiver holds off
        apply_settings(16'd5, 16'd3, 16'd6, 3'd3);
        hold_req = 1'b1;
        run_random(130, 1'b0, STALL_NONE);

        apply_settings(16'd1, 16'd1, 16'd1, 3'd1);
        run_random(100, 1'b1, STALL_HEAVY);

        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7);
        run_random(60, 1'b1, STALL_PERIODIC);

        apply_settings(16'd2, 16'd4, 16'd3, 3'd2);
        run_random(120, 1'b1, STALL_LIGHT);

        apply_settings(TIMER_W'($urandom_range(1, 12)), TIMER_W'($urandom_range(1, 12)),
                       TIMER_W'($urandom_range(1, 12)), ATTEMPT_W'($urandom_range(1, 7)));
        run_random(100, 1'b1, STALL_PERIODIC);

        drain(10);
        $display("Sent %0d key/tick transactions, checked %0d results over %0d register settings.",
                 items_sent, sb.checked, settings_used);
        $display("Saw %0d of 15 event kinds; input was held off on %0d cycles.",
                 $countones(sb.seen_events), input_held);
        if (sb.pending() != 0)
            $display("%0d expected results never arrived", sb.pending());
        if (sb.failures == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
